FILE: src/compacting_set_store_macros.svh
// ----------------------------------------------------------------------------
// compacting set store assertion macros
// shared concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef COMPACTING_SET_STORE_MACROS_SVH
`define COMPACTING_SET_STORE_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define CSS_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSS_ASSERT_ALWAYS(label, clk, rst, cond)
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// types, codes and defaults shared by the compacting set store
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int CAPACITY_DEFAULT   = 16;
  localparam int ELEM_WIDTH_DEFAULT = 16;

  // request kinds
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] element_value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
    logic [4:0] occupancy;
    logic       empty_flag;
    logic       full_flag;
  } rsp_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCATE,
    S_APPLY
  } state_t;

endpackage

FILE: src/css_cell.sv
// ----------------------------------------------------------------------------
// css_cell
// one slot of the store: holds an entry, compares it, shifts from its neighbor
// ----------------------------------------------------------------------------
module css_cell #(
  parameter int IDX        = 0,
  parameter int ELEM_WIDTH = css_pkg::ELEM_WIDTH_DEFAULT,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  css_pkg::cell_ctrl_t   ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [IDX_W-1:0]      pos,
  input  logic [ELEM_WIDTH-1:0] cmp_value,
  input  logic [ELEM_WIDTH-1:0] wr_value,
  input  logic [ELEM_WIDTH-1:0] neighbor,
  output logic [ELEM_WIDTH-1:0] entry,
  output logic                  hit
);

  logic occupied;
  logic at_tail;
  logic at_or_above;

  assign occupied    = count > CNT_W'(IDX);
  assign at_tail     = count == CNT_W'(IDX);
  assign at_or_above = IDX_W'(IDX) >= pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit <= occupied && (entry == cmp_value);
    end
  end

  // append at the tail, or close the gap left by a removed entry
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && at_tail) begin
      entry <= wr_value;
    end else if (ctrl.del_en && at_or_above) begin
      entry <= neighbor;
    end
  end

endmodule

FILE: src/css_locate.sv
// ----------------------------------------------------------------------------
// css_locate
// turns the registered hit vector into a position and a presence flag
// ----------------------------------------------------------------------------
module css_locate #(
  parameter int CAPACITY = css_pkg::CAPACITY_DEFAULT,
  parameter int IDX_W    = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic [CAPACITY-1:0] hit,
  output logic [IDX_W-1:0]    pos,
  output logic                present
);

  logic [IDX_W-1:0] pos_c;

  // values are distinct, so at most one hit bit is set
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        pos_c = pos_c | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos     <= pos_c;
      present <= |hit;
    end
  end

endmodule

FILE: src/compacting_set_store.sv
// ----------------------------------------------------------------------------
// compacting_set_store
// set of distinct values in a left-packed row of cells with insert/delete/query
// ----------------------------------------------------------------------------
// sequence: the cells compare the request as it is taken, locate registers
//   its position, then apply registers the response, waiting while the output
//   is stalled; no new request is taken until the sequencer is back in idle
// reset: clears the member count, which empties the set; entry contents are
//   left as they are and no clearing pass runs
module compacting_set_store #(
  parameter int CAPACITY   = css_pkg::CAPACITY_DEFAULT,
  parameter int ELEM_WIDTH = css_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  css_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output css_pkg::rsp_t rsp_data
);

`include "compacting_set_store_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  css_pkg::state_t     state, state_next;
  css_pkg::cell_ctrl_t ctrl;

  logic [CNT_W-1:0]      count, count_next;
  logic [1:0]            req_q;
  logic [ELEM_WIDTH-1:0] value_q;
  logic [ELEM_WIDTH-1:0] cmp_value;

  logic [CAPACITY-1:0]   hit;
  logic [ELEM_WIDTH-1:0] entry [CAPACITY];
  logic [IDX_W-1:0]      pos;
  logic                  present;

  logic req_take;
  logic locate_en;
  logic apply_go;
  logic rsp_free;
  logic is_ins, is_del, is_full;
  logic ins_ok, del_ok;
  logic [1:0] status_c;
  css_pkg::rsp_t rsp_c;

  // upper value bits beyond the element width are dropped
  assign cmp_value = ELEM_WIDTH'(req_data.element_value);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= css_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      css_pkg::S_IDLE: begin
        if (req_valid) state_next = css_pkg::S_LOCATE;
      end
      css_pkg::S_LOCATE: state_next = css_pkg::S_APPLY;
      css_pkg::S_APPLY: begin
        if (rsp_free) state_next = css_pkg::S_IDLE;
      end
      default: state_next = css_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    locate_en = 1'b0;
    apply_go  = 1'b0;
    unique case (state)
      css_pkg::S_IDLE:   req_stall = 1'b0;
      css_pkg::S_LOCATE: locate_en = 1'b1;
      css_pkg::S_APPLY:  apply_go  = rsp_free;
      default:           req_stall = 1'b1;
    endcase
  end

  // latch the request; the cells compare against it in the same edge
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q   <= req_data.req_type;
      value_q <= cmp_value;
    end
  end

  // ---------------- decision ----------------
  // kind 3 falls through as a query
  assign is_ins  = req_q == css_pkg::REQ_INSERT;
  assign is_del  = req_q == css_pkg::REQ_DELETE;
  assign is_full = count >= CNT_W'(CAPACITY);
  // presence wins over fullness on insert
  assign ins_ok  = is_ins && !present && !is_full;
  assign del_ok  = is_del && present;

  always_comb begin
    status_c = css_pkg::ST_DONE;
    if (is_ins && present) begin
      status_c = css_pkg::ST_PRESENT;
    end else if (is_ins && is_full) begin
      status_c = css_pkg::ST_FULL;
    end else if (is_del && !present) begin
      status_c = css_pkg::ST_ABSENT;
    end
  end

  assign count_next = count + CNT_W'(ins_ok) - CNT_W'(del_ok);

  always_comb begin
    rsp_c.found      = present;
    rsp_c.status     = status_c;
    rsp_c.occupancy  = 5'(count_next);
    rsp_c.empty_flag = count_next == '0;
    rsp_c.full_flag  = count_next == CNT_W'(CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp_data <= rsp_c;
    end
  end

  // ---------------- cell row ----------------
  assign ctrl.cmp_en = req_take;
  assign ctrl.ins_en = apply_go && ins_ok;
  assign ctrl.del_en = apply_go && del_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] nb;
    // the last cell has no right neighbor; what it takes lies past the count
    if (i == CAPACITY - 1) begin : g_last
      assign nb = entry[i];
    end else begin : g_mid
      assign nb = entry[i+1];
    end

    css_cell #(
      .IDX        (i),
      .ELEM_WIDTH (ELEM_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (count),
      .pos       (pos),
      .cmp_value (cmp_value),
      .wr_value  (value_q),
      .neighbor  (nb),
      .entry     (entry[i]),
      .hit       (hit[i])
    );
  end

  css_locate #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_locate (
    .clk     (clk),
    .en      (locate_en),
    .hit     (hit),
    .pos     (pos),
    .present (present)
  );

  // ---------------- assertions ----------------
  `CSS_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `CSS_ASSERT_ALWAYS(a_hit_unique, clk, rst, $onehot0(hit))
  `CSS_ASSERT_NEXT(a_take_to_locate, clk, rst, req_take, state == css_pkg::S_LOCATE)
  `CSS_ASSERT_NEXT(a_apply_gives_rsp, clk, rst, apply_go, rsp_valid)
  `CSS_ASSERT_IMPL(a_del_needs_member, clk, rst, ctrl.del_en, count != '0)

endmodule

FILE: tb/sv/compacting_set_store_tb.sv
// ----------------------------------------------------------------------------
// compacting_set_store_tb
// self-checking bench for the compacting set store: a directed opening covers
// the empty, full, duplicate, absent and undefined-kind cases, then several
// hundred random requests drawn mostly from a small value pool keep the set
// filling and draining. a scoreboard keeps its own copy of the set and checks
// every response transaction field by field, in order.
// ----------------------------------------------------------------------------
module compacting_set_store_tb;

  localparam int SET_CAPACITY = css_pkg::CAPACITY_DEFAULT;
  localparam int NUM_RANDOM   = 450;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 50000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_AT      = 200;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 380;

  // undefined request kind, handled by the block as a query
  localparam logic [1:0] REQ_UNDEF = 2'd3;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  css_pkg::req_t  req_data = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  css_pkg::rsp_t  rsp_data;

  compacting_set_store DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // scoreboard copy of the set, left-packed like the block's store
  logic [15:0] set_members[SET_CAPACITY];
  int          set_size = 0;

  css_pkg::req_t pending_reqs[$];
  css_pkg::rsp_t expected_rsps[$];
  int          reqs_sent = 0;
  int          rsps_seen = 0;
  int          failures = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [15:0] value_pool[POOL_SIZE];

  initial begin
    forever #4 clk = ~clk;
  end

  // apply one request to the scoreboard set and return the response it causes
  function automatic css_pkg::rsp_t apply_request(input css_pkg::req_t r);
    int            pos;
    css_pkg::rsp_t res;
    pos = -1;
    for (int i = 0; i < set_size; i++) begin
      if (pos < 0 && set_members[i] == r.element_value) pos = i;
    end
    res.found  = (pos >= 0);
    res.status = css_pkg::ST_DONE;
    case (r.req_type)
      css_pkg::REQ_INSERT: begin
        if (pos >= 0) begin
          res.status = css_pkg::ST_PRESENT;   // presence wins over fullness
        end else if (set_size >= SET_CAPACITY) begin
          res.status = css_pkg::ST_FULL;
        end else begin
          set_members[set_size] = r.element_value;
          set_size++;
        end
      end
      css_pkg::REQ_DELETE: begin
        if (pos >= 0) begin
          // close the gap, keeping the order of the later members
          for (int j = pos; j < set_size - 1; j++) set_members[j] = set_members[j + 1];
          set_size--;
        end else begin
          res.status = css_pkg::ST_ABSENT;
        end
      end
      default: ;                     // query and the undefined kind change nothing
    endcase
    res.occupancy  = 5'(set_size);
    res.empty_flag = (set_size == 0);
    res.full_flag  = (set_size == SET_CAPACITY);
    return res;
  endfunction

  function automatic css_pkg::req_t make_req(input logic [1:0] kind,
                                             input logic [15:0] value);
    css_pkg::req_t r;
    r.req_type      = kind;
    r.element_value = value;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      failures++;
    end
  endfunction

  // driver: presents pending requests, predicts on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_data  <= '0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(apply_request(req_data));
        reqs_sent++;
      end
      // a stalled transaction stays on the bus untouched
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
        end else if (!(reqs_sent >= QUIET_FROM && reqs_sent < QUIET_TO) &&
                     $urandom_range(99) < 10) begin
          req_valid <= 1'b0;         // random sender gap
        end else begin
          req_valid <= 1'b1;
          req_data  <= pending_reqs.pop_front();
        end
      end
    end
  end

  // monitor: checks responses in order and drives the response stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response transaction with no request outstanding");
          failures++;
        end else begin
          css_pkg::rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          check_field("found", 32'(exp_rsp.found), 32'(rsp_data.found));
          check_field("status", 32'(exp_rsp.status), 32'(rsp_data.status));
          check_field("occupancy", 32'(exp_rsp.occupancy), 32'(rsp_data.occupancy));
          check_field("empty_flag", 32'(exp_rsp.empty_flag), 32'(rsp_data.empty_flag));
          check_field("full_flag", 32'(exp_rsp.full_flag), 32'(rsp_data.full_flag));
        end
        rsps_seen++;
      end
      // one long hold-off while the driver keeps offering, so the block backs up
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && rsps_seen >= HOLD_AT) begin
        rsp_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else if (rsps_seen >= QUIET_FROM && rsps_seen < QUIET_TO) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          pick;
    logic [1:0]  kind;
    logic [15:0] value;

    value_pool[0] = 16'h0000;
    value_pool[1] = 16'hFFFF;
    value_pool[2] = 16'h8000;
    value_pool[3] = 16'h0001;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = 16'($urandom);

    // directed opening: empty set, extremes, duplicates, filling to capacity
    pending_reqs.push_back(make_req(css_pkg::REQ_QUERY, 16'h0000));   // query on empty set
    pending_reqs.push_back(make_req(css_pkg::REQ_DELETE, 16'h0000));  // delete on empty set
    pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'h0000));
    pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'hFFFF));
    pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'hFFFF));  // already present
    pending_reqs.push_back(make_req(css_pkg::REQ_QUERY, 16'hFFFF));
    pending_reqs.push_back(make_req(REQ_UNDEF, 16'hFFFF));            // undefined kind
    for (int i = 1; i <= SET_CAPACITY - 2; i++) begin
      pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'(i * 16'h1111 ^ 16'h5A5A)));
    end
    pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'h1234));  // absent into full set
    pending_reqs.push_back(make_req(css_pkg::REQ_INSERT, 16'hFFFF));  // present into full set
    pending_reqs.push_back(make_req(css_pkg::REQ_DELETE, 16'h0000));  // first entry, all shift
    pending_reqs.push_back(make_req(css_pkg::REQ_DELETE, 16'h4321));  // absent on nonempty set

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender pause: let every outstanding response come back
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);

    // random part: alternate fill-heavy, drain-heavy and mixed stretches
    for (int k = 0; k < NUM_RANDOM; k++) begin
      phase = (k / 60) % 3;
      pick  = $urandom_range(99);
      case (phase)
        0:       kind = (pick < 70) ? css_pkg::REQ_INSERT :
                        (pick < 80) ? css_pkg::REQ_DELETE :
                        (pick < 95) ? css_pkg::REQ_QUERY : REQ_UNDEF;
        1:       kind = (pick < 15) ? css_pkg::REQ_INSERT :
                        (pick < 75) ? css_pkg::REQ_DELETE :
                        (pick < 95) ? css_pkg::REQ_QUERY : REQ_UNDEF;
        default: kind = (pick < 40) ? css_pkg::REQ_INSERT :
                        (pick < 70) ? css_pkg::REQ_DELETE :
                        (pick < 95) ? css_pkg::REQ_QUERY : REQ_UNDEF;
      endcase
      if ($urandom_range(99) < 85) value = value_pool[$urandom_range(POOL_SIZE - 1)];
      else value = 16'($urandom);
      pending_reqs.push_back(make_req(kind, value));
    end

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
    // catch any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0 && expected_rsps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
